### rtl/dnlc_pkg.sv
`timescale 1ns / 1ps
package dnlc_pkg;

  localparam logic [2:0] REQ_ENTER     = 3'd0;
  localparam logic [2:0] REQ_LOOKUP    = 3'd1;
  localparam logic [2:0] REQ_REMOVE    = 3'd2;
  localparam logic [2:0] REQ_PURGE_ALL = 3'd3;
  localparam logic [2:0] REQ_PURGE_ID  = 3'd4;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_MISS     = 3'd1;
  localparam logic [2:0] STS_TOO_LONG = 3'd2;
  localparam logic [2:0] STS_CACHED   = 3'd3;
  localparam logic [2:0] STS_DISABLED = 3'd4;

  typedef struct packed {
    logic        valid;
    logic        mark;
    logic [31:0] dir;
    logic [31:0] tgt;
    logic [63:0] nlo;
    logic [55:0] nhi;
    logic [3:0]  len;
    logic [15:0] cred;
  } entry_t;

  typedef struct packed {
    logic [31:0] dir;
    logic [7:0]  len;
    logic [63:0] nlo;
    logic [55:0] nhi;
    logic [15:0] cred;
    logic [31:0] tgt;
  } key_t;

  typedef struct packed {
    logic take_up;
    logic take_dn;
    logic set_mark;
    logic mark_val;
  } cell_ctl_t;

  typedef struct packed {
    logic name_hit;
    logic cred_hit;
    logic id_hit;
  } cell_sts_t;

  function automatic logic [63:0] low_mask(input logic [7:0] len);
    logic [63:0] m;
    if (len >= 8'd8) m = '1;
    else m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
    return m;
  endfunction

  function automatic logic [55:0] high_mask(input logic [7:0] len);
    logic [55:0] m;
    if (len <= 8'd8) m = '0;
    else if (len >= 8'd15) m = '1;
    else m = (56'd1 << {len[2:0], 3'b000}) - 56'd1;
    return m;
  endfunction

endpackage

### rtl/directory_name_lru_cache.sv
`timescale 1ns / 1ps
// Name lookup cache: ENTRIES slots map (dir, name, cred) to a target id, LRU replacement.
// Input channel in_* (valid/ready) carries one request per beat; output channel out_*
// returns one result beat per request, in order.
// Slots live in a chain of cells ordered by recency: cell 0 is least recent, the top cell
// most recent. All cells compare against a request in the cycle it is accepted.
// Enter and lookup do their work on accept (compare and chain shift), then emit the result.
// Remove and purges free one marked slot per cycle, moving it to cell 0.
// The result waits in an output register; while that register still holds an untaken
// result, the block waits in S_DRAIN with the next one and in_ready stays low.
// cfg_we/cfg_wdata writes cache_enable (reset 1) with no wait.
// Reset (rst_n low, synchronous) invalidates all slots; no clearing pass is needed.
module directory_name_lru_cache #(
  parameter int ENTRIES      = 64,
  parameter int MAX_NAME_LEN = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_dir_id,
  input  logic [7:0]  in_name_len,
  input  logic [63:0] in_name_low,
  input  logic [55:0] in_name_high,
  input  logic [31:0] in_target_id,
  input  logic [15:0] in_cred_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_found_id,
  output logic [6:0]  out_removed_count,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   en_r;
  logic [2:0]  res_sts_r, res_sts_nxt;
  logic [31:0] res_fid_r, res_fid_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        out_valid_r;
  logic [2:0]  out_sts_r;
  logic [31:0] out_fid_r;
  logic [6:0]  out_cnt_r;

  dnlc_pkg::key_t      key;
  dnlc_pkg::entry_t    ent   [ENTRIES];
  dnlc_pkg::cell_sts_t sts   [ENTRIES];
  dnlc_pkg::cell_ctl_t ctl   [ENTRIES];
  dnlc_pkg::entry_t    inject, new_ent;

  logic [ENTRIES-1:0] hv, mv, mark_new;
  logic [IW-1:0] hp, mp, pos;
  logic hit_any, mark_any, too_long, accept, act_top, act_bot, set_mark, emit;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign too_long = in_name_len > 8'(MAX_NAME_LEN);

  assign key.dir  = in_dir_id;
  assign key.len  = in_name_len;
  assign key.nlo  = in_name_low & dnlc_pkg::low_mask(in_name_len);
  assign key.nhi  = in_name_high & dnlc_pkg::high_mask(in_name_len);
  assign key.cred = in_cred_id;
  assign key.tgt  = in_target_id;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hv[i] = sts[i].name_hit && sts[i].cred_hit;
      mv[i] = ent[i].mark;
      mark_new[i] = ((in_req_type == dnlc_pkg::REQ_REMOVE) && sts[i].name_hit) ||
                    ((in_req_type == dnlc_pkg::REQ_PURGE_ALL) && ent[i].valid) ||
                    ((in_req_type == dnlc_pkg::REQ_PURGE_ID) && sts[i].id_hit);
    end
  end

  always_comb begin
    hp = '0;
    mp = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hv[i]) hp = IW'(i);
      if (mv[i]) mp = IW'(i);
    end
  end

  assign hit_any  = |hv;
  assign mark_any = |mv;

  always_comb begin
    new_ent       = '0;
    new_ent.valid = 1'b1;
    new_ent.dir   = key.dir;
    new_ent.tgt   = key.tgt;
    new_ent.nlo   = key.nlo;
    new_ent.nhi   = key.nhi;
    new_ent.len   = key.len[3:0];
    new_ent.cred  = key.cred;
  end

  always_comb begin
    state_nxt   = state_r;
    res_sts_nxt = res_sts_r;
    res_fid_nxt = res_fid_r;
    cnt_nxt     = cnt_r;
    act_top     = 1'b0;
    act_bot     = 1'b0;
    set_mark    = 1'b0;
    pos         = '0;
    inject      = ent[0];
    inject.valid = 1'b0;
    inject.mark  = 1'b0;
    emit        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_DRAIN;
          res_sts_nxt = dnlc_pkg::STS_OK;
          res_fid_nxt = '0;
          cnt_nxt     = '0;
          case (in_req_type)
            dnlc_pkg::REQ_ENTER, dnlc_pkg::REQ_LOOKUP: begin
              if (!en_r) res_sts_nxt = dnlc_pkg::STS_DISABLED;
              else if (too_long) res_sts_nxt = dnlc_pkg::STS_TOO_LONG;
              else if (in_req_type == dnlc_pkg::REQ_ENTER) begin
                if (hit_any) res_sts_nxt = dnlc_pkg::STS_CACHED;
                else begin
                  act_top = 1'b1;
                  inject  = new_ent;
                end
              end else if (hit_any) begin
                res_fid_nxt = ent[hp].tgt;
                act_top     = 1'b1;
                pos         = hp;
                inject      = ent[hp];
                inject.mark = 1'b0;
              end else res_sts_nxt = dnlc_pkg::STS_MISS;
            end
            dnlc_pkg::REQ_REMOVE: begin
              if (too_long) res_sts_nxt = dnlc_pkg::STS_TOO_LONG;
              else set_mark = 1'b1;
            end
            dnlc_pkg::REQ_PURGE_ALL, dnlc_pkg::REQ_PURGE_ID: set_mark = 1'b1;
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        if (mark_any) begin
          act_bot = 1'b1;
          pos     = mp;
          cnt_nxt = cnt_r + 7'd1;
        end else if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    dnlc_pkg::entry_t up_d, dn_d;
    assign up_d = (g == ENTRIES - 1) ? inject : ent[(g == ENTRIES - 1) ? g : g + 1];
    assign dn_d = (g == 0) ? inject : ent[(g == 0) ? g : g - 1];
    assign ctl[g].take_up  = act_top && (IW'(g) >= pos);
    assign ctl[g].take_dn  = act_bot && (IW'(g) <= pos);
    assign ctl[g].set_mark = set_mark;
    assign ctl[g].mark_val = mark_new[g];
    dnlc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl[g]),
      .ent_up (up_d),
      .ent_dn (dn_d),
      .key    (key),
      .ent_q  (ent[g]),
      .sts    (sts[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) en_r <= cfg_wdata;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_sts_r <= res_sts_nxt;
    res_fid_r <= res_fid_nxt;
    cnt_r     <= cnt_nxt;
    if (emit) begin
      out_sts_r <= res_sts_r;
      out_fid_r <= res_fid_r;
      out_cnt_r <= cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_sts_r;
  assign out_found_id      = out_fid_r;
  assign out_removed_count = out_cnt_r;

  a_idle_no_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mark_any) else $error("marks left while idle");
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(hv) <= 1) else $error("duplicate cache entries");
  a_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DRAIN)) else $error("accept did not start request");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready)) else $error("result overwritten");

endmodule

### rtl/dnlc_cell.sv
`timescale 1ns / 1ps
module dnlc_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dnlc_pkg::cell_ctl_t ctl,
  input  dnlc_pkg::entry_t   ent_up,
  input  dnlc_pkg::entry_t   ent_dn,
  input  dnlc_pkg::key_t     key,
  output dnlc_pkg::entry_t   ent_q,
  output dnlc_pkg::cell_sts_t sts
);

  dnlc_pkg::entry_t ent_r;
  dnlc_pkg::entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.take_up) ent_nxt = ent_up;
    else if (ctl.take_dn) ent_nxt = ent_dn;
    else if (ctl.set_mark) ent_nxt.mark = ctl.mark_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      ent_r.mark  <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
      ent_r.mark  <= ent_nxt.mark;
    end
    ent_r.dir  <= ent_nxt.dir;
    ent_r.tgt  <= ent_nxt.tgt;
    ent_r.nlo  <= ent_nxt.nlo;
    ent_r.nhi  <= ent_nxt.nhi;
    ent_r.len  <= ent_nxt.len;
    ent_r.cred <= ent_nxt.cred;
  end

  assign ent_q = ent_r;
  assign sts.name_hit = ent_r.valid && (ent_r.dir == key.dir) &&
                        ({4'b0000, ent_r.len} == key.len) &&
                        (ent_r.nlo == key.nlo) && (ent_r.nhi == key.nhi);
  assign sts.cred_hit = (ent_r.cred == key.cred);
  assign sts.id_hit   = ent_r.valid && ((ent_r.dir == key.tgt) || (ent_r.tgt == key.tgt));

endmodule
